@@ rtl/pla_pkg.sv @@
// Shared types, constants and helpers for the paged linear allocator.
package pla_pkg;

  // Pool and field sizes
  localparam int MAX_PAGES   = 256;
  localparam int PAGE_IDX_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PAGE_CNT_W  = $clog2(MAX_PAGES + 1);
  localparam int OFFSET_BITS = 24;
  localparam int SIZE_W      = 25;
  localparam int ALIGN_W     = 5;
  localparam int PIDX_OUT_W  = 8;

  localparam logic [SIZE_W-1:0] PAGE_SIZE_RST = SIZE_W'(2097152);

  // Request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_RESET = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_PAGE   = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] size_bytes;
    logic [ALIGN_W-1:0] align_log2;
  } pla_req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [PIDX_OUT_W-1:0]  page_index;
    logic [OFFSET_BITS-1:0] offset;
    logic                   new_page;
  } pla_rsp_t;

  // Round v up to a multiple of 2^lg. Any nonzero value rounded to 2^SIZE_W or more
  // saturates at 2^SIZE_W, which exceeds every legal page size.
  function automatic logic [SIZE_W:0] align_up(input logic [SIZE_W-1:0] v,
                                               input logic [ALIGN_W-1:0] lg);
    logic [SIZE_W-1:0] m;
    logic [SIZE_W:0]   s;
    m = '0;
    s = '0;
    if (lg >= ALIGN_W'(SIZE_W)) begin
      align_up = (v == '0) ? '0 : {1'b1, {SIZE_W{1'b0}}};
    end else begin
      m = (SIZE_W'(1) << lg) - SIZE_W'(1);
      s = {1'b0, v} + {1'b0, m};
      align_up = s & ~{1'b0, m};
    end
  endfunction

endpackage

@@ rtl/paged_linear_allocator.sv @@
// Paged linear allocator: bump allocation over a pool of fixed-size pages.
//
//   port group  dir  handshake         payload
//   in_         in   in_valid/in_stall  pla_req_t  (type, size, alignment)
//   out_        out  out_valid/out_stall pla_rsp_t (status, page, offset, new)
//   cfg_        in   cfg_we             page size, 25 bits
//
// One request per cycle while in_stall is low: the align-up adds and the fit
// compare sit between the allocator state and the result register, which takes
// a result unless a result is stalled, when the result goes to the skid register.
// Reset (rst_n low, synchronous) restores a page size of 2 MiB and an empty
// pool. A two-entry output (result register plus skid register) lets one
// more request in while a result is stalled; in_stall rises only when both
// entries are full.
module paged_linear_allocator
  import pla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pla_req_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pla_rsp_t          out_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  // Allocator state
  logic [SIZE_W-1:0]     page_size_r;
  logic                  page_open_r, page_open_nxt;
  logic [PAGE_IDX_W-1:0] current_page_r, current_page_nxt;
  logic [SIZE_W-1:0]     fill_offset_r, fill_offset_nxt;
  logic [PAGE_CNT_W-1:0] pages_made_r, pages_made_nxt;
  logic [PAGE_CNT_W-1:0] next_reuse_r, next_reuse_nxt;

  // Output buffering
  logic     out_valid_r, skid_valid_r;
  pla_rsp_t out_data_r, skid_data_r;
  pla_rsp_t rsp;

  logic            in_acc, out_take;
  logic [SIZE_W:0] asz, aoff;
  logic [SIZE_W+1:0] fit_end;
  logic            too_large, fits;

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_acc    = in_valid & ~skid_valid_r;
  assign out_take  = out_valid_r & ~out_stall;

  // Align size and current fill, test against the page
  assign asz       = align_up(in_data.size_bytes, in_data.align_log2);
  assign aoff      = align_up(fill_offset_r, in_data.align_log2);
  assign fit_end   = {1'b0, aoff} + {1'b0, asz};
  assign too_large = (in_data.size_bytes > page_size_r) ||
                     (asz > {1'b0, page_size_r});
  assign fits      = page_open_r && (fit_end <= {2'b00, page_size_r});

  // Compute the result and the next allocator state
  always_comb begin
    rsp              = '0;
    rsp.status       = ST_OK;
    page_open_nxt    = page_open_r;
    current_page_nxt = current_page_r;
    fill_offset_nxt  = fill_offset_r;
    pages_made_nxt   = pages_made_r;
    next_reuse_nxt   = next_reuse_r;
    priority if (in_data.req_type == REQ_RESET) begin
      page_open_nxt    = 1'b0;
      current_page_nxt = '0;
      fill_offset_nxt  = '0;
      next_reuse_nxt   = '0;
    end else if (too_large) begin
      rsp.status = ST_TOO_LARGE;
    end else if (fits) begin
      fill_offset_nxt = fit_end[SIZE_W-1:0];
      rsp.page_index  = PIDX_OUT_W'(current_page_r);
      rsp.offset      = aoff[OFFSET_BITS-1:0];
    end else if (next_reuse_r < pages_made_r) begin
      // reuse a page made before the last reset
      page_open_nxt    = 1'b1;
      current_page_nxt = next_reuse_r[PAGE_IDX_W-1:0];
      fill_offset_nxt  = asz[SIZE_W-1:0];
      next_reuse_nxt   = next_reuse_r + PAGE_CNT_W'(1);
      rsp.page_index   = PIDX_OUT_W'(next_reuse_r[PAGE_IDX_W-1:0]);
      rsp.new_page     = 1'b1;
    end else if (pages_made_r < PAGE_CNT_W'(MAX_PAGES)) begin
      // make a fresh page
      page_open_nxt    = 1'b1;
      current_page_nxt = pages_made_r[PAGE_IDX_W-1:0];
      fill_offset_nxt  = asz[SIZE_W-1:0];
      pages_made_nxt   = pages_made_r + PAGE_CNT_W'(1);
      next_reuse_nxt   = pages_made_r + PAGE_CNT_W'(1);
      rsp.page_index   = PIDX_OUT_W'(pages_made_r[PAGE_IDX_W-1:0]);
      rsp.new_page     = 1'b1;
    end else begin
      rsp.status = ST_NO_PAGE;
    end
  end

  // Update configuration and allocator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r    <= PAGE_SIZE_RST;
      page_open_r    <= 1'b0;
      current_page_r <= '0;
      fill_offset_r  <= '0;
      pages_made_r   <= '0;
      next_reuse_r   <= '0;
    end else begin
      if (cfg_we) begin
        page_size_r <= cfg_wdata;
      end
      if (in_acc) begin
        page_open_r    <= page_open_nxt;
        current_page_r <= current_page_nxt;
        fill_offset_r  <= fill_offset_nxt;
        pages_made_r   <= pages_made_nxt;
        next_reuse_r   <= next_reuse_nxt;
      end
    end
  end

  // Advance results through the result and skid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_acc) begin
        out_data_r <= rsp;
      end
    end else if (in_acc) begin
      skid_data_r <= rsp;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a result in front of it");

  a_reuse_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_reuse_r <= pages_made_r)
    else $error("reuse pointer passed the number of pages made");

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pages_made_r <= PAGE_CNT_W'(MAX_PAGES))
    else $error("more pages made than the pool holds");

  a_open_page_taken: assert property (@(posedge clk) disable iff (!rst_n)
    page_open_r |-> (PAGE_CNT_W'(current_page_r) < next_reuse_r))
    else $error("open page not among the pages taken since reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");
`endif

endmodule

@@ dv/pla_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the paged linear allocator: tracks placements and compares results.
module pla_checker
  import pla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  pla_req_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  pla_rsp_t          out_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending
);

  // Allocator state as the checker sees it
  logic [63:0] page_bytes = 64'(PAGE_SIZE_RST);
  logic        page_open = 1'b0;
  int unsigned cur_page = 0;
  logic [63:0] fill = '0;
  int unsigned pages_made = 0;
  int unsigned next_reuse = 0;
  int          errs = 0;

  pla_rsp_t placements[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [63:0] round_up(logic [63:0] v, logic [ALIGN_W-1:0] lg);
    logic [63:0] m;
    m = (64'd1 << lg) - 64'd1;
    return (v + m) & ~m;
  endfunction

  // Work out the placement of one request and advance the allocator state
  function automatic pla_rsp_t place(pla_req_t r);
    pla_rsp_t    rsp;
    logic [63:0] asz;
    logic [63:0] aoff;
    int unsigned idx;
    rsp = '0;
    if (r.req_type == REQ_RESET) begin
      page_open = 1'b0;
      cur_page = 0;
      fill = '0;
      next_reuse = 0;
      return rsp;
    end
    asz = round_up(64'(r.size_bytes), r.align_log2);
    if (64'(r.size_bytes) > page_bytes || asz > page_bytes) begin
      rsp.status = ST_TOO_LARGE;
      return rsp;
    end
    // try to bump within the open page
    if (page_open) begin
      aoff = round_up(fill, r.align_log2);
      if (aoff + asz <= page_bytes) begin
        fill = aoff + asz;
        rsp.page_index = cur_page[PIDX_OUT_W-1:0];
        rsp.offset = aoff[OFFSET_BITS-1:0];
        return rsp;
      end
    end
    // take a released page first, then a fresh one
    if (next_reuse < pages_made) begin
      idx = next_reuse;
      next_reuse++;
    end else if (pages_made < MAX_PAGES) begin
      idx = pages_made;
      pages_made++;
      next_reuse = pages_made;
    end else begin
      rsp.status = ST_NO_PAGE;
      return rsp;
    end
    page_open = 1'b1;
    cur_page = idx;
    fill = asz;
    rsp.page_index = idx[PIDX_OUT_W-1:0];
    rsp.new_page = 1'b1;
    return rsp;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errs++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    pla_rsp_t want;
    if (!rst_n) begin
      page_bytes = 64'(PAGE_SIZE_RST);
      page_open = 1'b0;
      cur_page = 0;
      fill = '0;
      pages_made = 0;
      next_reuse = 0;
      placements.delete();
    end else begin
      // compare the result leaving the block against the oldest placement
      if (out_valid && !out_stall) begin
        if (placements.size() == 0) begin
          errs++;
          $error("result with no request outstanding: %p", out_data);
        end else begin
          want = placements[0];
          placements.delete(0);
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("page_index", 32'(want.page_index), 32'(out_data.page_index));
          check_field("offset", 32'(want.offset), 32'(out_data.offset));
          check_field("new_page", 32'(want.new_page), 32'(out_data.new_page));
        end
      end
      if (cfg_we) page_bytes = 64'(cfg_wdata);
      if (in_valid && !in_stall) placements.insert(placements.size(), place(in_data));
    end
    fail_count <= errs;
    pending <= placements.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the paged linear allocator: clock, reset, stimulus and verdict.
module tb_top;
  import pla_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  pla_req_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  pla_rsp_t          out_data;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;
  int                fail_count;
  int                pending;
  bit                gaps_on = 1'b1;
  int                n_sent = 0;
  int                n_cfg = 0;

  always #2 clk = ~clk;

  paged_linear_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pla_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Bound the run
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Stall the result channel in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (gaps_on && rst_n && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one request and hold it until taken
  task automatic send(pla_req_t r);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic alloc(int unsigned size, int unsigned lg);
    pla_req_t r;
    r.req_type = REQ_ALLOC;
    r.size_bytes = SIZE_W'(size);
    r.align_log2 = ALIGN_W'(lg);
    send(r);
  endtask

  task automatic release_all(int unsigned size, int unsigned lg);
    pla_req_t r;
    r.req_type = REQ_RESET;
    r.size_bytes = SIZE_W'(size);
    r.align_log2 = ALIGN_W'(lg);
    send(r);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_page_size(logic [SIZE_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  // Random request, biased toward sizes that fit the page
  function automatic pla_req_t rand_req(logic [SIZE_W-1:0] psz, int unsigned reset_pct);
    pla_req_t    r;
    int unsigned k;
    int unsigned lim;
    r.req_type = ($urandom_range(0, 99) < reset_pct) ? REQ_RESET : REQ_ALLOC;
    lim = 32'(psz) / 4 + 1;
    k = $urandom_range(0, 99);
    if (k < 50) r.size_bytes = SIZE_W'($urandom_range(0, lim));
    else if (k < 65) r.size_bytes = SIZE_W'($urandom_range(0, 32'(psz)));
    else if (k < 75) r.size_bytes = psz;
    else if (k < 85) r.size_bytes = psz + SIZE_W'($urandom_range(1, 4));
    else r.size_bytes = SIZE_W'($urandom);
    k = $urandom_range(0, 99);
    if (k < 80) r.align_log2 = ALIGN_W'($urandom_range(0, 6));
    else if (k < 95) r.align_log2 = ALIGN_W'($urandom_range(7, 16));
    else r.align_log2 = ALIGN_W'($urandom_range(17, 31));
    return r;
  endfunction

  initial begin
    logic [SIZE_W-1:0] psz;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Default 2 MiB page: basic bumps, oversize, page end, huge alignment
    alloc(0, 0);
    alloc(1, 0);
    alloc(100, 4);
    alloc(16777216, 0);
    alloc(33554431, 31);
    alloc(2097152, 0);
    alloc(0, 0);
    alloc(5, 31);
    alloc(0, 31);
    alloc(1000, 16);
    alloc(3, 17);
    // release everything, then walk the released pages in order
    release_all(33554431, 31);
    alloc(10, 3);
    alloc(2097152, 0);
    alloc(2097152, 0);
    alloc(1, 0);

    // Zero-byte page
    set_page_size('0);
    alloc(0, 0);
    alloc(1, 0);
    alloc(0, 5);

    // Full 16 MiB page: offset at the end wraps in the offset field
    set_page_size(SIZE_W'(16777216));
    alloc(16777216, 0);
    alloc(0, 0);
    alloc(0, 24);

    set_page_size(SIZE_W'(1));
    alloc(1, 0);
    alloc(1, 1);

    set_page_size('1);
    alloc(33554431, 0);
    alloc(0, 0);

    // Tiny pages: every request opens a page until the pool runs dry
    set_page_size(SIZE_W'(16));
    repeat (280) alloc($urandom_range(9, 16), $urandom_range(0, 4));
    release_all(0, 0);
    repeat (20) alloc($urandom_range(0, 16), $urandom_range(0, 4));

    // Random phases over several page sizes; the last one runs without gaps
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: psz = PAGE_SIZE_RST;
        1: psz = SIZE_W'($urandom_range(16, 4096));
        2: psz = SIZE_W'(16777216);
        3: psz = SIZE_W'($urandom);
        default: psz = SIZE_W'($urandom_range(1, 64));
      endcase
      set_page_size(psz);
      if (ph == 4) gaps_on = 1'b0;
      repeat (90) send(rand_req(psz, 4));
    end

    drain();
    repeat (5) @(posedge clk);
    $display("Covered %0d requests over %0d page-size settings: edge sizes and alignments,",
             n_sent, n_cfg);
    $display("pool exhaustion, page reuse after release, and random traffic with stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
